[hw/rtl/rmma_pkg.sv]
// rmma_pkg: sizes, payload structs and controller/datapath links
// for the range mode-then-add block; no dependencies
`default_nettype none

package rmma_pkg;

  localparam int unsigned CELLS   = 1024;
  localparam int unsigned IDX_W   = $clog2(CELLS);
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CNT_W   = $clog2(CELLS + 1);
  localparam int unsigned VAL_W   = 4;
  localparam int unsigned NVALUES = 9;
  localparam int unsigned PICK_W  = $clog2(NVALUES);

  localparam logic [VAL_W-1:0] CELL_RESET = VAL_W'(1);
  localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(1024);
  localparam logic             KIND_RANGE = 1'b0;
  localparam logic             KIND_READ  = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [9:0]      first_index;
    logic [9:0]      last_index;
  } in_t;

  typedef struct packed {
    logic [3:0]      value;
    logic            bad_range;
  } out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic cell_read;
    logic capture;
    logic scan;
    logic pick;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic at_last;
    logic pick_last;
    logic bad;
    logic is_read;
    logic best_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hw/rtl/rmma_ram.sv]
// rmma_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module rmma_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/rmma_ctrl.sv]
// rmma_ctrl: sequencer for clearing, reads, range scans, mode pick and update
// depends on rmma_pkg
`default_nettype none

module rmma_ctrl import rmma_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_RDCELL = 11'b000_0000_0100,
    ST_RDCAP  = 11'b000_0000_1000,
    ST_SCAN   = 11'b000_0001_0000,
    ST_SDRAIN = 11'b000_0010_0000,
    ST_PICK   = 11'b000_0100_0000,
    ST_PDEC   = 11'b000_1000_0000,
    ST_UPD    = 11'b001_0000_0000,
    ST_UDRAIN = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RDCELL;
        end
      end
      ST_RDCELL: begin
        // load results are visible here
        if (stat_i.bad) begin
          state_d = ST_EMIT;
        end else if (stat_i.is_read) begin
          cmd_o.cell_read = 1'b1;
          state_d         = ST_RDCAP;
        end else begin
          cmd_o.scan = 1'b1;
          if (stat_i.at_last) state_d = ST_SDRAIN;
          else state_d = ST_SCAN;
        end
      end
      ST_RDCAP: begin
        cmd_o.capture = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.at_last) state_d = ST_SDRAIN;
      end
      ST_SDRAIN: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        if (stat_i.pick_last) state_d = ST_PDEC;
      end
      ST_PDEC: begin
        if (stat_i.best_zero) state_d = ST_EMIT;
        else state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        if (stat_i.at_last) state_d = ST_UDRAIN;
      end
      ST_UDRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/rmma_dp.sv]
// rmma_dp: cell memory, address counter, value counters, mode pick and output register
// depends on rmma_pkg and rmma_ram
`default_nettype none

module rmma_dp import rmma_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire in_t              in_data_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output out_t                  out_data_o,
  input  wire cmd_t             cmd_i,
  output stat_t                 stat_o
);

  logic [CFG_W-1:0]  cfg_q;
  logic [IDX_W-1:0]  addr_q, first_q, last_q, wb_addr_q;
  logic              kind_q, bad_q;
  logic [VAL_W-1:0]  best_q;
  logic [PICK_W-1:0] pick_q;
  logic [CNT_W-1:0]  cnt_q [NVALUES];
  logic              cnt_en_q, wr_en_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [CFG_W-1:0]  n_cells;
  logic              bad_d;
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  sum_mod;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;

  assign n_cells = (cfg_q > CFG_W'(CELLS)) ? CFG_W'(CELLS) : cfg_q;

  always_comb begin
    if (in_data_i.kind == KIND_READ) begin
      bad_d = ({1'b0, in_data_i.first_index} >= n_cells);
    end else begin
      bad_d = (in_data_i.first_index > in_data_i.last_index) ||
              ({1'b0, in_data_i.last_index} >= n_cells);
    end
  end

  assign sum     = {1'b0, rdata} + {1'b0, best_q};
  assign sum_mod = (sum >= (VAL_W+1)'(NVALUES)) ? VAL_W'(sum - (VAL_W+1)'(NVALUES))
                                                 : VAL_W'(sum);

  assign ram_we    = cmd_i.clear | wr_en_q;
  assign ram_waddr = cmd_i.clear ? addr_q : wb_addr_q;
  assign ram_wdata = cmd_i.clear ? CELL_RESET : sum_mod;

  rmma_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      addr_q      <= '0;
      cnt_en_q    <= 1'b0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      cnt_en_q <= cmd_i.scan;
      wr_en_q  <= cmd_i.update;
      if (cmd_i.clear || cmd_i.scan || cmd_i.update) begin
        addr_q <= addr_q + IDX_W'(1);
      end else if (cmd_i.load) begin
        addr_q <= in_data_i.first_index;
      end else if (cmd_i.pick && (pick_q == PICK_W'(NVALUES - 1))) begin
        addr_q <= first_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= addr_q;
    if (cmd_i.load) begin
      first_q <= in_data_i.first_index;
      last_q  <= in_data_i.last_index;
      kind_q  <= in_data_i.kind;
      bad_q   <= bad_d;
      best_q  <= '0;
      pick_q  <= '0;
      for (int v = 0; v < NVALUES; v++) begin
        cnt_q[v] <= '0;
      end
    end else begin
      if (cnt_en_q) begin
        for (int v = 0; v < NVALUES; v++) begin
          if (rdata == VAL_W'(v)) cnt_q[v] <= cnt_q[v] + CNT_W'(1);
        end
      end
      if (cmd_i.pick) begin
        if (cnt_q[pick_q] >= cnt_q[best_q[PICK_W-1:0]]) best_q <= VAL_W'(pick_q);
        pick_q <= pick_q + PICK_W'(1);
      end
      if (cmd_i.capture) best_q <= rdata;
    end
    if (cmd_i.emit) begin
      out_q.value     <= best_q;
      out_q.bad_range <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.clear_last = (addr_q == IDX_W'(CELLS - 1));
  assign stat_o.at_last    = (addr_q == last_q);
  assign stat_o.pick_last  = (pick_q == PICK_W'(NVALUES - 1));
  assign stat_o.bad        = bad_q;
  assign stat_o.is_read    = (kind_q == KIND_READ);
  assign stat_o.best_zero  = (best_q == '0);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

[hw/rtl/range_mode_then_modular_add.sv]
// range_mode_then_modular_add: top level, joins controller and datapath
// depends on rmma_pkg, rmma_ctrl, rmma_dp (and rmma_ram through it)
//
//  channel | signals                          | transfer when
//  in      | in_valid_i in_stall_o in_data_i  | valid high, stall low
//  out     | out_valid_o out_stall_i out_data_o| valid high, stall low
//  cfg     | cfg_valid_i cfg_ready_o cfg_data_i| valid and ready high
//
// after reset a clearing pass writes 1 to all 1024 cells, input stalled
// read item: load, cell read, capture, then emit to the output register; bad indices go straight to emit
// range item: one cell memory access per cycle for the scan, a pick over the value counters,
// then, unless the picked mode is 0, a read-modify-write pass
// a new item is taken while the previous result still waits on a stalled output
`default_nettype none

module range_mode_then_modular_add import rmma_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  rmma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rmma_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transfer");

  a_bad_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_range) |-> (out_data_o.value == 4'd0))
    else $error("bad range with nonzero value");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.value < 4'd9))
    else $error("result value out of range");

endmodule

`default_nettype wire

[tb/range_mode_then_modular_add_test.sv]
// range_mode_then_modular_add_test: directed table then random range and read items,
// checked against an in-bench cell-row predictor; depends on rmma_pkg and the block
`timescale 1ns / 1ps

module range_mode_then_modular_add_test;
  import rmma_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  logic [VAL_W-1:0] cell_row [CELLS];
  int unsigned      cells_active;
  out_t             pending_results [$];
  plan_row_t        plan [$];
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      stall_left = 0;

  range_mode_then_modular_add dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_t mode_and_add(in_t it);
    out_t        res;
    int unsigned tally [NVALUES];
    int unsigned best;
    res = '0;
    if (it.kind == KIND_READ) begin
      if (it.first_index >= cells_active) res.bad_range = 1'b1;
      else res.value = cell_row[it.first_index];
      return res;
    end
    if (it.first_index > it.last_index || it.last_index >= cells_active) begin
      res.bad_range = 1'b1;
      return res;
    end
    foreach (tally[v]) tally[v] = 0;
    for (int i = it.first_index; i <= it.last_index; i++) tally[cell_row[i] % NVALUES]++;
    best = 0;
    for (int v = 0; v < NVALUES; v++) if (tally[v] >= tally[best]) best = v;
    if (best != 0)
      for (int i = it.first_index; i <= it.last_index; i++)
        cell_row[i] = VAL_W'((cell_row[i] + best) % NVALUES);
    res.value = VAL_W'(best);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic pause_cycles(int unsigned n);
    repeat (n) @(negedge clk_i);
  endtask

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(in_t it, bit fixed, out_t want);
    out_t        predicted;
    int unsigned gap;
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = mode_and_add(it);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk_i);
    gap = gap_length();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      pause_cycles(gap);
    end
  endtask

  task automatic write_cells_in_use(logic [CFG_W-1:0] n);
    in_valid_i = 1'b0;
    wait (pending_results.size() == 0);
    pause_cycles(20);
    cfg_valid_i = 1'b1;
    cfg_data_i  = n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cells_active = (n > CELLS) ? CELLS : n;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = CFG_W'($urandom);
  endtask

  function automatic in_t random_item(int unsigned n);
    in_t it;
    it = $bits(in_t)'($urandom);
    if (n == 0 || $urandom_range(0, 99) < 15) return it;
    it.kind = ($urandom_range(0, 99) < 30) ? KIND_READ : KIND_RANGE;
    if ($urandom_range(0, 99) < 2) begin
      it.first_index = '0;
      it.last_index  = IDX_W'(n - 1);
    end else begin
      it.first_index = IDX_W'($urandom_range(0, n - 1));
      it.last_index  = IDX_W'(it.first_index + $urandom_range(0, 15));
      if (it.last_index >= n || it.last_index < it.first_index) it.last_index = IDX_W'(n - 1);
    end
    return it;
  endfunction

  function automatic plan_row_t make_row(logic kind, int f, int l, bit fixed, int v, bit bad);
    plan_row_t r;
    r.item.kind        = kind;
    r.item.first_index = IDX_W'(f);
    r.item.last_index  = IDX_W'(l);
    r.fixed            = fixed;
    r.want.value       = VAL_W'(v);
    r.want.bad_range   = bad;
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_left  = gap_length();
      out_stall_i = (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("range_mode_then_modular_add_test failed");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_data_o.value, -1);
      end else begin
        if (out_data_o.value != pending_results[0].value)
          report_mismatch("value", out_data_o.value, pending_results[0].value);
        if (out_data_o.bad_range != pending_results[0].bad_range)
          report_mismatch("bad_range", out_data_o.bad_range, pending_results[0].bad_range);
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    int unsigned phase_size [7] = '{120, 30, 200, 300, 150, 100, 150};
    logic [CFG_W-1:0] phase_cfg [7] = '{11'd1, 11'd0, 11'd2047, 11'd37, 11'd1024, 11'd5, 11'd300};
    foreach (cell_row[i]) cell_row[i] = CELL_RESET;
    cells_active = CELLS;
    pause_cycles(2);
    rst_ni = 1'b1;

    plan.push_back(make_row(KIND_READ,  0,    0,    1, 1, 0));
    plan.push_back(make_row(KIND_READ,  1023, 0,    1, 1, 0));
    plan.push_back(make_row(KIND_RANGE, 0,    1023, 1, 1, 0));
    plan.push_back(make_row(KIND_READ,  1023, 1023, 1, 2, 0));
    plan.push_back(make_row(KIND_RANGE, 5,    4,    1, 0, 1));
    plan.push_back(make_row(KIND_RANGE, 1023, 0,    1, 0, 1));
    plan.push_back(make_row(KIND_RANGE, 0,    0,    0, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 0,    0,    0, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 0,    0,    0, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 0,    2,    0, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 0,    0,    1, 0, 0));
    plan.push_back(make_row(KIND_READ,  0,    0,    1, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 0,    1,    0, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 1023, 1023, 0, 0, 0));
    plan.push_back(make_row(KIND_READ,  3,    1023, 0, 0, 0));
    plan.push_back(make_row(KIND_RANGE, 1,    3,    0, 0, 0));
    plan.push_back(make_row(KIND_READ,  2,    0,    0, 0, 0));
    foreach (plan[i]) send_item(plan[i].item, plan[i].fixed, plan[i].want);

    foreach (phase_cfg[p]) begin
      write_cells_in_use(phase_cfg[p]);
      repeat (phase_size[p]) send_item(random_item(cells_active), 1'b0, '0);
    end

    in_valid_i = 1'b0;
    wait (pending_results.size() == 0);
    pause_cycles(50);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("range_mode_then_modular_add_test passed");
    end else begin
      $display("range_mode_then_modular_add_test failed");
    end
    $finish;
  end

endmodule
